>>> rtl/chua_eul_pkg.sv
// ----------------------------------------------------------------------------
// chua_eul_pkg
// shared types, register map and reset constants for the chua euler integrator
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package chua_eul_pkg;

	// default number format: signed q8.24
	localparam int DATA_WIDTH_DEF = 32;
	localparam int FRAC_BITS_DEF  = 24;

	// configuration register widths
	localparam int CFG_DATA_W = 32;
	localparam int CFG_IDX_W  = 2;
	localparam int ALPHA_W    = 31;
	localparam int BETA_W     = 31;
	localparam int STEP_W     = 25;
	localparam int INIT_W     = 32;

	// register reset values
	localparam logic [ALPHA_W-1:0] ALPHA_RST  = 31'd115762790;
	localparam logic [BETA_W-1:0]  BETA_RST   = 31'd167772160;
	localparam logic [STEP_W-1:0]  STEP_RST   = 25'd167772;
	localparam logic [INIT_W-1:0]  INIT_X_RST = 32'd3355443;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ALPHA  = 2'd0,
		REG_BETA   = 2'd1,
		REG_STEP   = 2'd2,
		REG_INIT_X = 2'd3
	} cfg_reg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LOAD,
		ST_PREP,
		ST_OFS,
		ST_MUL_H,
		ST_ERR,
		ST_MUL_A,
		ST_MUL_DX,
		ST_DIFF,
		ST_SUMZ,
		ST_MUL_DY,
		ST_NEGB,
		ST_MUL_B,
		ST_MUL_DZ,
		ST_UPD,
		ST_DONE
	} seq_state_t;

	typedef enum logic [1:0] {
		MUL_IDLE,
		MUL_RUN,
		MUL_RND,
		MUL_FIN
	} mul_state_t;

	// status from the serial multiplier to the sequencer
	typedef struct packed {
		logic idle;
		logic done;
		logic sat;
	} mul_stat_t;

endpackage

>>> rtl/chua_oscillator_euler_step.sv
// ----------------------------------------------------------------------------
// chua_oscillator_euler_step
// forward euler step of a chua oscillator in signed fixed point
// a step beat gives its new point once the update after its multiplier passes
// is done; a restart beat gives the point from init_x with y and z at zero
// one beat is in flight at a time; the next is taken once the output register
// holds the last point; each step runs six dependent passes on one bit-serial multiplier
// arst_n sets the configuration registers to their defaults and the point to (0.2, 0, 0)
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module chua_oscillator_euler_step import chua_eul_pkg::*; #(
	parameter int DATA_WIDTH = DATA_WIDTH_DEF,
	parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// configuration write channel
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	// input beats
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  restart,
	// result beats
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [DATA_WIDTH-1:0] x_out,
	output logic [DATA_WIDTH-1:0] y_out,
	output logic [DATA_WIDTH-1:0] z_out,
	output logic                  saturated
);

	// extended width that holds any register value and any data value
	localparam int EW = ((DATA_WIDTH > INIT_W) ? DATA_WIDTH : INIT_W) + 1;

	localparam logic [DATA_WIDTH-1:0] VMAX_D = {1'b0, {(DATA_WIDTH-1){1'b1}}};
	localparam logic [DATA_WIDTH-1:0] VMIN_D = {1'b1, {(DATA_WIDTH-1){1'b0}}};
	localparam logic [DATA_WIDTH-1:0] ZERO_D = '0;
	localparam logic [EW-1:0] VMAX_E =
		{{(EW-DATA_WIDTH+1){1'b0}}, {(DATA_WIDTH-1){1'b1}}};
	localparam logic [EW-1:0] VMIN_E = ~VMAX_E;

	// diode constants and the reset x, clipped silently to the data range
	localparam logic [63:0] VMAX_64  = (64'd1 << (DATA_WIDTH - 1)) - 64'd1;
	localparam logic [63:0] ONE_64   = 64'd1 << FRAC_BITS;
	localparam logic [63:0] THREE_64 = 64'd3 << FRAC_BITS;
	localparam logic [63:0] K7_64    = ((64'd1 << (FRAC_BITS + 1)) + 64'd7) / 64'd14;
	localparam logic [63:0] XRST_64  = {{(64-INIT_W){1'b0}}, INIT_X_RST};
	localparam logic [DATA_WIDTH-1:0] ONE_C =
		(ONE_64 > VMAX_64) ? VMAX_D : ONE_64[DATA_WIDTH-1:0];
	localparam logic [DATA_WIDTH-1:0] THREE_C =
		(THREE_64 > VMAX_64) ? VMAX_D : THREE_64[DATA_WIDTH-1:0];
	localparam logic [DATA_WIDTH-1:0] K7_C =
		(K7_64 > VMAX_64) ? VMAX_D : K7_64[DATA_WIDTH-1:0];
	localparam logic [DATA_WIDTH-1:0] NEG_ONE_C =
		~ONE_C + {{(DATA_WIDTH-1){1'b0}}, 1'b1};
	localparam logic [DATA_WIDTH-1:0] X_RST_C =
		(XRST_64 > VMAX_64) ? VMAX_D : XRST_64[DATA_WIDTH-1:0];

	// saturating arithmetic, msb of the result is the clip flag
	function automatic logic [DATA_WIDTH:0] sat_add(input logic [DATA_WIDTH-1:0] a,
	                                                input logic [DATA_WIDTH-1:0] b);
		logic [DATA_WIDTH:0] s;
		s = {a[DATA_WIDTH-1], a} + {b[DATA_WIDTH-1], b};
		if (s[DATA_WIDTH] != s[DATA_WIDTH-1]) begin
			return {1'b1, s[DATA_WIDTH] ? VMIN_D : VMAX_D};
		end
		return {1'b0, s[DATA_WIDTH-1:0]};
	endfunction

	function automatic logic [DATA_WIDTH:0] sat_sub(input logic [DATA_WIDTH-1:0] a,
	                                                input logic [DATA_WIDTH-1:0] b);
		logic [DATA_WIDTH:0] s;
		s = {a[DATA_WIDTH-1], a} - {b[DATA_WIDTH-1], b};
		if (s[DATA_WIDTH] != s[DATA_WIDTH-1]) begin
			return {1'b1, s[DATA_WIDTH] ? VMIN_D : VMAX_D};
		end
		return {1'b0, s[DATA_WIDTH-1:0]};
	endfunction

	function automatic logic [DATA_WIDTH:0] clip_ext(input logic [EW-1:0] v);
		if ($signed(v) > $signed(VMAX_E)) return {1'b1, VMAX_D};
		if ($signed(v) < $signed(VMIN_E)) return {1'b1, VMIN_D};
		return {1'b0, v[DATA_WIDTH-1:0]};
	endfunction

	// configuration registers
	logic [ALPHA_W-1:0] alpha_q;
	logic [BETA_W-1:0]  beta_q;
	logic [STEP_W-1:0]  step_q;
	logic [INIT_W-1:0]  init_x_q;

	// point and step control
	seq_state_t            state_q, state_nx;
	logic [DATA_WIDTH-1:0] x_q, y_q, z_q;
	logic                  sat_q;
	logic                  out_valid_q;
	logic                  out_load;
	logic                  in_acc;

	// working registers of one step
	logic [DATA_WIDTH-1:0] alpha_c_q, beta_c_q, dt_c_q;
	logic [DATA_WIDTH-1:0] tmp_q, dx_q, dy_q;
	logic                  x_lo_q, x_mid_q;
	logic [DATA_WIDTH-1:0] x_out_q, y_out_q, z_out_q;
	logic                  sat_out_q;

	// multiplier hookup
	logic                  mul_start;
	logic [DATA_WIDTH-1:0] mul_a, mul_b, mul_p;
	mul_stat_t             mul_stat;

	// saturating clips, adds and subtracts; the msb of each is its clip flag
	logic [DATA_WIDTH:0] alpha_cl, beta_cl, dt_cl, init_cl;
	logic [DATA_WIDTH:0] dbl_x, neg_x, ofs_lo, ofs_hi;
	logic [DATA_WIDTH:0] err_r, diff_r, sumz_r, negb_r;
	logic [DATA_WIDTH:0] upd_x, upd_y, upd_z;
	logic                x_lo, x_mid;

	assign alpha_cl = clip_ext({{(EW-ALPHA_W){1'b0}}, alpha_q});
	assign beta_cl  = clip_ext({{(EW-BETA_W){1'b0}}, beta_q});
	assign dt_cl    = clip_ext({{(EW-STEP_W){1'b0}}, step_q});
	assign init_cl  = clip_ext({{(EW-INIT_W){init_x_q[INIT_W-1]}}, init_x_q});

	// diode segment select and its first term
	assign x_lo  = $signed(x_q) <= $signed(NEG_ONE_C);
	assign x_mid = !x_lo && ($signed(x_q) < $signed(ONE_C));
	assign dbl_x = sat_add(x_q, x_q);
	assign neg_x = sat_sub(ZERO_D, x_q);
	assign ofs_lo = sat_add(tmp_q, THREE_C);
	assign ofs_hi = sat_sub(tmp_q, THREE_C);

	// right-hand sides, all from the old point
	assign err_r  = sat_sub(y_q, tmp_q);
	assign diff_r = sat_sub(x_q, y_q);
	assign sumz_r = sat_add(tmp_q, z_q);
	assign negb_r = sat_sub(ZERO_D, beta_c_q);

	assign upd_x = sat_add(x_q, dx_q);
	assign upd_y = sat_add(y_q, dy_q);
	assign upd_z = sat_add(z_q, tmp_q);

	assign cfg_ready = 1'b1;
	assign in_acc    = in_valid && in_ready;
	// the output register frees up when empty or when its beat leaves
	assign out_load  = (state_q == ST_DONE) && (!out_valid_q || out_ready);

	assign out_valid = out_valid_q;
	assign x_out     = x_out_q;
	assign y_out     = y_out_q;
	assign z_out     = z_out_q;
	assign saturated = sat_out_q;

	chua_eul_mul #(
		.DATA_WIDTH (DATA_WIDTH),
		.FRAC_BITS  (FRAC_BITS)
	) u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.op_a    (mul_a),
		.op_b    (mul_b),
		.product (mul_p),
		.stat    (mul_stat)
	);

	// step sequencer: next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE:   if (in_acc) state_nx = restart ? ST_LOAD : ST_PREP;
			ST_LOAD:   state_nx = ST_DONE;
			ST_PREP:   state_nx = ST_OFS;
			ST_OFS:    state_nx = ST_MUL_H;
			ST_MUL_H:  if (mul_stat.done) state_nx = ST_ERR;
			ST_ERR:    state_nx = ST_MUL_A;
			ST_MUL_A:  if (mul_stat.done) state_nx = ST_MUL_DX;
			ST_MUL_DX: if (mul_stat.done) state_nx = ST_DIFF;
			ST_DIFF:   state_nx = ST_SUMZ;
			ST_SUMZ:   state_nx = ST_MUL_DY;
			ST_MUL_DY: if (mul_stat.done) state_nx = ST_NEGB;
			ST_NEGB:   state_nx = ST_MUL_B;
			ST_MUL_B:  if (mul_stat.done) state_nx = ST_MUL_DZ;
			ST_MUL_DZ: if (mul_stat.done) state_nx = ST_UPD;
			ST_UPD:    state_nx = ST_DONE;
			ST_DONE:   if (out_load) state_nx = ST_IDLE;
			default:   state_nx = ST_IDLE;
		endcase
	end

	// step sequencer: handshake and multiplier operands
	always_comb begin
		in_ready  = 1'b0;
		mul_start = 1'b0;
		mul_a     = tmp_q;
		mul_b     = dt_c_q;
		unique case (state_q) inside
			ST_IDLE: in_ready = 1'b1;
			ST_MUL_H: begin
				mul_start = mul_stat.idle;
				mul_b     = K7_C;
			end
			ST_MUL_A: begin
				mul_start = mul_stat.idle;
				mul_a     = alpha_c_q;
				mul_b     = tmp_q;
			end
			ST_MUL_B: begin
				mul_start = mul_stat.idle;
				mul_b     = y_q;
			end
			// each increment is scaled by dt
			ST_MUL_DX, ST_MUL_DY, ST_MUL_DZ: mul_start = mul_stat.idle;
			ST_LOAD, ST_PREP, ST_OFS, ST_ERR, ST_DIFF, ST_SUMZ, ST_NEGB, ST_UPD,
			ST_DONE: ;
			default: ;
		endcase
	end

	// control state, configuration and the point itself
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			alpha_q     <= ALPHA_RST;
			beta_q      <= BETA_RST;
			step_q      <= STEP_RST;
			init_x_q    <= INIT_X_RST;
			x_q         <= X_RST_C;
			y_q         <= '0;
			z_q         <= '0;
			sat_q       <= 1'b0;
		end else begin
			state_q <= state_nx;

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			if (cfg_valid && cfg_ready) begin
				unique case (cfg_reg_t'(cfg_index))
					REG_ALPHA:  alpha_q  <= cfg_data[ALPHA_W-1:0];
					REG_BETA:   beta_q   <= cfg_data[BETA_W-1:0];
					REG_STEP:   step_q   <= cfg_data[STEP_W-1:0];
					REG_INIT_X: init_x_q <= cfg_data[INIT_W-1:0];
					default: ;
				endcase
			end

			// clip flag gathers every saturation of the current step
			case (state_q)
				ST_IDLE: if (in_acc) sat_q <= 1'b0;
				ST_LOAD: begin
					x_q   <= init_cl[DATA_WIDTH-1:0];
					y_q   <= '0;
					z_q   <= '0;
					sat_q <= init_cl[DATA_WIDTH];
				end
				ST_PREP: begin
					sat_q <= sat_q | alpha_cl[DATA_WIDTH] | beta_cl[DATA_WIDTH]
					       | dt_cl[DATA_WIDTH]
					       | (x_mid ? neg_x[DATA_WIDTH] : dbl_x[DATA_WIDTH]);
				end
				ST_OFS: begin
					if (x_lo) begin
						sat_q <= sat_q | ofs_lo[DATA_WIDTH];
					end else if (!x_mid_q) begin
						sat_q <= sat_q | ofs_hi[DATA_WIDTH];
					end
				end
				ST_ERR:  sat_q <= sat_q | err_r[DATA_WIDTH];
				ST_DIFF: sat_q <= sat_q | diff_r[DATA_WIDTH];
				ST_SUMZ: sat_q <= sat_q | sumz_r[DATA_WIDTH];
				ST_NEGB: sat_q <= sat_q | negb_r[DATA_WIDTH];
				ST_MUL_H, ST_MUL_A, ST_MUL_DX, ST_MUL_DY, ST_MUL_B, ST_MUL_DZ: begin
					if (mul_stat.done) sat_q <= sat_q | mul_stat.sat;
				end
				ST_UPD: begin
					x_q   <= upd_x[DATA_WIDTH-1:0];
					y_q   <= upd_y[DATA_WIDTH-1:0];
					z_q   <= upd_z[DATA_WIDTH-1:0];
					sat_q <= sat_q | upd_x[DATA_WIDTH] | upd_y[DATA_WIDTH]
					       | upd_z[DATA_WIDTH];
				end
				default: ;
			endcase
		end
	end

	// datapath registers of the running step and the output register
	always_ff @(posedge clk) begin
		case (state_q)
			ST_PREP: begin
				alpha_c_q <= alpha_cl[DATA_WIDTH-1:0];
				beta_c_q  <= beta_cl[DATA_WIDTH-1:0];
				dt_c_q    <= dt_cl[DATA_WIDTH-1:0];
				x_lo_q    <= x_lo;
				x_mid_q   <= x_mid;
				tmp_q     <= x_mid ? neg_x[DATA_WIDTH-1:0] : dbl_x[DATA_WIDTH-1:0];
			end
			ST_OFS: begin
				if (x_lo_q) begin
					tmp_q <= ofs_lo[DATA_WIDTH-1:0];
				end else if (!x_mid_q) begin
					tmp_q <= ofs_hi[DATA_WIDTH-1:0];
				end
			end
			ST_ERR:  tmp_q <= err_r[DATA_WIDTH-1:0];
			ST_DIFF: tmp_q <= diff_r[DATA_WIDTH-1:0];
			ST_SUMZ: tmp_q <= sumz_r[DATA_WIDTH-1:0];
			ST_NEGB: tmp_q <= negb_r[DATA_WIDTH-1:0];
			ST_MUL_H, ST_MUL_A, ST_MUL_B, ST_MUL_DZ: begin
				if (mul_stat.done) tmp_q <= mul_p;
			end
			ST_MUL_DX: if (mul_stat.done) dx_q <= mul_p;
			ST_MUL_DY: if (mul_stat.done) dy_q <= mul_p;
			default: ;
		endcase

		if (out_load) begin
			x_out_q   <= x_q;
			y_out_q   <= y_q;
			z_out_q   <= z_q;
			sat_out_q <= sat_q;
		end
	end

endmodule

>>> rtl/chua_eul_mul.sv
// ----------------------------------------------------------------------------
// chua_eul_mul
// bit-serial signed fixed-point multiplier, floored and saturated
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module chua_eul_mul import chua_eul_pkg::*; #(
	parameter int DATA_WIDTH = DATA_WIDTH_DEF,
	parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [DATA_WIDTH-1:0] op_a,
	input  logic [DATA_WIDTH-1:0] op_b,
	output logic [DATA_WIDTH-1:0] product,
	output mul_stat_t             stat
);

	localparam int PW    = 2 * DATA_WIDTH;
	localparam int CNT_W = $clog2(DATA_WIDTH);
	localparam logic [DATA_WIDTH-1:0] VMAX_D = {1'b0, {(DATA_WIDTH-1){1'b1}}};
	localparam logic [DATA_WIDTH-1:0] VMIN_D = {1'b1, {(DATA_WIDTH-1){1'b0}}};
	localparam logic [PW-1:0] FRAC_MASK = ~({PW{1'b1}} << FRAC_BITS);

	mul_state_t state_q, state_nx;
	logic [CNT_W-1:0]      cnt_q;
	logic                  neg_q;
	logic [DATA_WIDTH-1:0] mcand_q;
	logic [DATA_WIDTH-1:0] mplier_q;
	logic [PW-1:0]         acc_q;
	logic [PW-1:0]         q_q;
	logic [DATA_WIDTH:0]   psum;
	logic [PW-1:0]         acc_nx;
	logic [PW-1:0]         q_rnd;
	logic [PW-1:0]         lim;
	logic                  over;

	function automatic logic [DATA_WIDTH-1:0] mag(input logic [DATA_WIDTH-1:0] v);
		return v[DATA_WIDTH-1] ? (~v + {{(DATA_WIDTH-1){1'b0}}, 1'b1}) : v;
	endfunction

	// shift-add: one multiplier bit per cycle, accumulator shifts right
	assign psum   = {1'b0, acc_q[PW-1:DATA_WIDTH]}
	              + (mplier_q[0] ? {1'b0, mcand_q} : {(DATA_WIDTH+1){1'b0}});
	assign acc_nx = {psum, acc_q[DATA_WIDTH-1:1]};

	// floor toward minus infinity on the magnitude of a negative product
	assign q_rnd = (acc_q >> FRAC_BITS)
	             + {{(PW-1){1'b0}}, (neg_q && ((acc_q & FRAC_MASK) != '0))};

	assign lim  = {{DATA_WIDTH{1'b0}}, VMAX_D} + {{(PW-1){1'b0}}, neg_q};
	assign over = q_q > lim;

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			MUL_IDLE: if (start) state_nx = MUL_RUN;
			MUL_RUN:  if (cnt_q == '0) state_nx = MUL_RND;
			MUL_RND:  state_nx = MUL_FIN;
			MUL_FIN:  state_nx = MUL_IDLE;
			default:  state_nx = MUL_IDLE;
		endcase
	end

	always_comb begin
		stat.idle = 1'b0;
		stat.done = 1'b0;
		stat.sat  = 1'b0;
		if (over) begin
			product = neg_q ? VMIN_D : VMAX_D;
		end else begin
			product = neg_q ? (~q_q[DATA_WIDTH-1:0] + {{(DATA_WIDTH-1){1'b0}}, 1'b1})
			                : q_q[DATA_WIDTH-1:0];
		end
		unique case (state_q)
			MUL_IDLE: stat.idle = 1'b1;
			MUL_RUN,
			MUL_RND: ;
			MUL_FIN: begin
				stat.done = 1'b1;
				stat.sat  = over;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= MUL_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_nx;
			if (state_q == MUL_IDLE && start) begin
				cnt_q <= CNT_W'(DATA_WIDTH - 1);
			end else if (state_q == MUL_RUN) begin
				cnt_q <= cnt_q - {{(CNT_W-1){1'b0}}, 1'b1};
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			MUL_IDLE: begin
				if (start) begin
					neg_q    <= op_a[DATA_WIDTH-1] ^ op_b[DATA_WIDTH-1];
					mcand_q  <= mag(op_a);
					mplier_q <= mag(op_b);
					acc_q    <= '0;
				end
			end
			MUL_RUN: begin
				acc_q    <= acc_nx;
				mplier_q <= mplier_q >> 1;
			end
			MUL_RND: q_q <= q_rnd;
			default: ;
		endcase
	end

endmodule
